// ----- rtl/envelope_point_interpolator_core_macros.svh -----
// Assertion helpers used by the envelope core controller (epi_ctrl).
`ifndef ENVELOPE_POINT_INTERPOLATOR_CORE_MACROS_SVH
`define ENVELOPE_POINT_INTERPOLATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define EPI_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("epi assertion failed");

// Next-cycle implication, disabled while reset is low.
`define EPI_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("epi assertion failed");

`endif

// ----- rtl/epi_pkg.sv -----
package epi_pkg;

    // Item kinds
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_RESTART = 2'd1;
    localparam logic [1:0] KIND_WRITE   = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENV_EN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_EN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUS_EN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SUS_IDX    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PT_COUNT   = 3'd6;
    localparam int unsigned CFG_DATA_W = 4;

    // Field widths
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned FRAME_W = 16;
    localparam int unsigned LEVEL_W = 7;

    // Divider: |level diff| (7b) times elapsed frames (16b)
    localparam int unsigned DIV_W   = LEVEL_W + FRAME_W;
    localparam int unsigned DIV_CNT_W = 5;

    // Table read address select
    localparam logic [1:0] RD_POS  = 2'd0;
    localparam logic [1:0] RD_POS1 = 2'd1;
    localparam logic [1:0] RD_LAST = 2'd2;
    localparam logic [1:0] RD_SUS  = 2'd3;

    // Current point update select
    localparam logic [1:0] PT_NONE = 2'd0;
    localparam logic [1:0] PT_LAST = 2'd1;
    localparam logic [1:0] PT_SUS  = 2'd2;
    localparam logic [1:0] PT_ADV  = 2'd3;

    // Level update select
    localparam logic [1:0] LV_NONE = 2'd0;
    localparam logic [1:0] LV_RD   = 2'd1;
    localparam logic [1:0] LV_NEXT = 2'd2;
    localparam logic [1:0] LV_DIV  = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [IDX_W-1:0]   point_index;
        logic [FRAME_W-1:0] point_frame;
        logic [LEVEL_W-1:0] point_level;
    } in_word_t;

    typedef struct packed {
        logic               active;
        logic [LEVEL_W-1:0] level;
        logic [IDX_W-1:0]   segment;
    } out_word_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [LEVEL_W-1:0] level;
    } pt_entry_t;

    typedef struct packed {
        logic       load_in;
        logic       wr_point;
        logic       restart;
        logic       pos_init;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic [1:0] pt_sel;
        logic [1:0] lv_sel;
        logic       frame_from_rd;
        logic       frame_inc;
        logic       latch_a;
        logic       latch_b;
        logic       div_load;
        logic       div_step;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       env_en;
        logic       loop_hit;
        logic       at_last;
        logic       sus_hit;
        logic       gap_zero;
        logic       div_last;
    } status_t;

endpackage

// ----- rtl/epi_ctrl.sv -----
`include "envelope_point_interpolator_core_macros.svh"

module epi_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             m_ready,
    output logic             m_valid,
    input  epi_pkg::status_t st,
    output epi_pkg::cmd_t    cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_LOOP_RD  = 4'd2;
    localparam logic [3:0] S_LOOP_SET = 4'd3;
    localparam logic [3:0] S_CHECK    = 4'd4;
    localparam logic [3:0] S_HOLD_LVL = 4'd5;
    localparam logic [3:0] S_ADV      = 4'd6;
    localparam logic [3:0] S_SEG      = 4'd7;
    localparam logic [3:0] S_LAST_LVL = 4'd8;
    localparam logic [3:0] S_RD_A     = 4'd9;
    localparam logic [3:0] S_RD_B     = 4'd10;
    localparam logic [3:0] S_PREP     = 4'd11;
    localparam logic [3:0] S_DIV      = 4'd12;
    localparam logic [3:0] S_FIN      = 4'd13;
    localparam logic [3:0] S_OUT      = 4'd14;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (st.kind)
                    epi_pkg::KIND_WRITE: begin
                        cmd.wr_point = 1'b1;
                        state_next   = S_OUT;
                    end
                    epi_pkg::KIND_RESTART: begin
                        cmd.restart = 1'b1;
                        state_next  = S_OUT;
                    end
                    epi_pkg::KIND_TICK: begin
                        if (st.env_en) begin
                            cmd.pos_init = 1'b1;
                            state_next   = st.loop_hit ? S_LOOP_RD : S_CHECK;
                        end else begin
                            state_next = S_OUT;
                        end
                    end
                    default: begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_LOOP_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = epi_pkg::RD_POS;
                state_next = S_LOOP_SET;
            end
            S_LOOP_SET: begin
                cmd.frame_from_rd = 1'b1;
                state_next        = S_CHECK;
            end
            S_CHECK: begin
                cmd.rd_en = 1'b1;
                if (st.at_last) begin
                    cmd.rd_sel = epi_pkg::RD_LAST;
                    cmd.pt_sel = epi_pkg::PT_LAST;
                    state_next = S_HOLD_LVL;
                end else if (st.sus_hit) begin
                    cmd.rd_sel = epi_pkg::RD_SUS;
                    cmd.pt_sel = epi_pkg::PT_SUS;
                    state_next = S_HOLD_LVL;
                end else begin
                    cmd.rd_sel = epi_pkg::RD_POS1;
                    state_next = S_ADV;
                end
            end
            S_HOLD_LVL: begin
                cmd.lv_sel = epi_pkg::LV_RD;
                state_next = S_OUT;
            end
            S_ADV: begin
                cmd.pt_sel = epi_pkg::PT_ADV;
                state_next = S_SEG;
            end
            S_SEG: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = epi_pkg::RD_POS;
                state_next = st.at_last ? S_LAST_LVL : S_RD_A;
            end
            S_LAST_LVL: begin
                cmd.lv_sel    = epi_pkg::LV_RD;
                cmd.frame_inc = 1'b1;
                state_next    = S_OUT;
            end
            S_RD_A: begin
                cmd.latch_a = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = epi_pkg::RD_POS1;
                state_next  = S_RD_B;
            end
            S_RD_B: begin
                cmd.latch_b = 1'b1;
                state_next  = S_PREP;
            end
            S_PREP: begin
                if (st.gap_zero) begin
                    cmd.lv_sel    = epi_pkg::LV_NEXT;
                    cmd.frame_inc = 1'b1;
                    state_next    = S_OUT;
                end else begin
                    cmd.div_load = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (st.div_last) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                cmd.lv_sel    = epi_pkg::LV_DIV;
                cmd.frame_inc = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output word never overwritten while it is still waiting.
    `EPI_ASSERT_NOW(a_no_overwrite, aclk, aresetn, m_valid_reg && !m_ready, !cmd.out_load)
    // Accepted word always goes to decode.
    `EPI_ASSERT_NXT(a_accept_decode, aclk, aresetn, s_valid && s_ready, state_reg == S_DECODE)
    // Divider finish leads to the level update.
    `EPI_ASSERT_NXT(a_div_fin, aclk, aresetn, state_reg == S_DIV && st.div_last, state_reg == S_FIN)
    // A loaded result is presented next cycle.
    `EPI_ASSERT_NXT(a_out_valid, aclk, aresetn, cmd.out_load, m_valid_reg)

endmodule

// ----- rtl/epi_dp.sv -----
module epi_dp #(
    parameter int unsigned MAX_POINTS = 12
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    input  logic [epi_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [epi_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  epi_pkg::in_word_t                    s_data,
    input  epi_pkg::cmd_t                        cmd,
    output epi_pkg::status_t                     st,
    output epi_pkg::out_word_t                   m_data
);

    localparam int unsigned AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CW  = 6;
    localparam int unsigned IW  = epi_pkg::IDX_W;
    localparam int unsigned FW  = epi_pkg::FRAME_W;
    localparam int unsigned LW  = epi_pkg::LEVEL_W;
    localparam int unsigned DW  = epi_pkg::DIV_W;
    localparam int unsigned NW  = epi_pkg::DIV_CNT_W;
    localparam logic [LW-1:0] LEVEL_MAX = '1;
    localparam logic [FW-1:0] FRAME_MAX = '1;

    // configuration
    logic          env_en_reg, loop_en_reg, sus_en_reg;
    logic [IW-1:0] loop_start_reg, loop_end_reg, sus_idx_reg, pt_count_reg;

    // envelope state
    logic [IW-1:0] cur_point_reg, pos_reg;
    logic [FW-1:0] cur_frame_reg;
    logic [LW-1:0] level_reg;

    // payload
    epi_pkg::in_word_t  item_reg;
    epi_pkg::pt_entry_t rd_data_reg;
    epi_pkg::pt_entry_t mem [MAX_POINTS];
    logic [FW-1:0]      a_frame_reg, b_frame_reg;
    logic [LW-1:0]      a_level_reg, b_level_reg;
    logic [FW-1:0]      div_rem_reg;
    logic [DW-1:0]      div_q_reg;
    logic [NW-1:0]      div_cnt_reg;
    logic               div_neg_reg;
    epi_pkg::out_word_t out_reg;

    logic [IW-1:0] count_eff, last_pt, ls_clamp, rd_idx, adv_pos;
    logic [AW-1:0] rd_addr;
    logic          wr_ok, adv;
    logic [FW-1:0] gap, elapsed;
    logic          lvl_up;
    logic [LW-1:0] dmag;
    logic [DW-1:0] prod;
    logic [FW:0]   trial;
    logic          q_bit;
    logic [FW-1:0] rem_next;
    logic [DW:0]   up_sum;
    logic [LW-1:0] div_level;

    // effective point count: zero reads as one, clamped to table depth
    always_comb begin
        count_eff = pt_count_reg;
        if (pt_count_reg == '0) begin
            count_eff = IW'(1);
        end else if ({{(CW-IW){1'b0}}, pt_count_reg} > CW'(MAX_POINTS)) begin
            count_eff = IW'(MAX_POINTS);
        end
    end
    assign last_pt  = count_eff - IW'(1);
    assign ls_clamp = (loop_start_reg > last_pt) ? last_pt : loop_start_reg;
    assign wr_ok    = ({{(CW-IW){1'b0}}, item_reg.point_index} < CW'(MAX_POINTS));

    always_comb begin
        case (cmd.rd_sel)
            epi_pkg::RD_POS:  rd_idx = pos_reg;
            epi_pkg::RD_POS1: rd_idx = pos_reg + IW'(1);
            epi_pkg::RD_LAST: rd_idx = last_pt;
            default:          rd_idx = sus_idx_reg;
        endcase
    end
    assign rd_addr = AW'(rd_idx);

    assign adv     = (rd_data_reg.frame <= cur_frame_reg);
    assign adv_pos = adv ? (pos_reg + IW'(1)) : pos_reg;

    // interpolation operands
    assign gap     = b_frame_reg - a_frame_reg;
    assign elapsed = cur_frame_reg - a_frame_reg;
    assign lvl_up  = (b_level_reg >= a_level_reg);
    assign dmag    = lvl_up ? (b_level_reg - a_level_reg) : (a_level_reg - b_level_reg);
    assign prod    = {{(DW-LW){1'b0}}, dmag} * {{(DW-FW){1'b0}}, elapsed};

    // one restoring division step
    assign trial    = {div_rem_reg, div_q_reg[DW-1]};
    assign q_bit    = (trial >= {1'b0, gap});
    assign rem_next = q_bit ? FW'(trial - {1'b0, gap}) : trial[FW-1:0];

    // signed truncating result added to the start level, clipped to level range
    assign up_sum = {1'b0, div_q_reg} + (DW+1)'(a_level_reg);
    always_comb begin
        if (div_neg_reg) begin
            div_level = (div_q_reg > DW'(a_level_reg)) ? '0
                                                         : (a_level_reg - div_q_reg[LW-1:0]);
        end else begin
            div_level = (up_sum > (DW+1)'(LEVEL_MAX)) ? LEVEL_MAX : up_sum[LW-1:0];
        end
    end

    assign st.kind     = item_reg.kind;
    assign st.env_en   = env_en_reg;
    assign st.loop_hit = loop_en_reg && (cur_point_reg >= loop_end_reg);
    assign st.at_last  = (pos_reg >= last_pt);
    assign st.sus_hit  = sus_en_reg && (pos_reg >= sus_idx_reg);
    assign st.gap_zero = (gap == '0);
    assign st.div_last = (div_cnt_reg == NW'(DW - 1));

    assign m_data = out_reg;

    // configuration and envelope state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            env_en_reg     <= 1'b0;
            loop_en_reg    <= 1'b0;
            sus_en_reg     <= 1'b0;
            loop_start_reg <= '0;
            loop_end_reg   <= '0;
            sus_idx_reg    <= '0;
            pt_count_reg   <= IW'(1);
            cur_point_reg  <= '0;
            cur_frame_reg  <= '0;
            level_reg      <= '0;
            pos_reg        <= '0;
            div_cnt_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    epi_pkg::CFG_ENV_EN:     env_en_reg     <= cfg_data[0];
                    epi_pkg::CFG_LOOP_EN:    loop_en_reg    <= cfg_data[0];
                    epi_pkg::CFG_SUS_EN:     sus_en_reg     <= cfg_data[0];
                    epi_pkg::CFG_LOOP_START: loop_start_reg <= cfg_data;
                    epi_pkg::CFG_LOOP_END:   loop_end_reg   <= cfg_data;
                    epi_pkg::CFG_SUS_IDX:    sus_idx_reg    <= cfg_data;
                    epi_pkg::CFG_PT_COUNT:   pt_count_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end

            if (cmd.restart) begin
                cur_point_reg <= '0;
                cur_frame_reg <= '0;
                level_reg     <= '0;
            end

            if (cmd.pos_init) begin
                pos_reg <= st.loop_hit ? ls_clamp : cur_point_reg;
            end

            case (cmd.pt_sel)
                epi_pkg::PT_LAST: cur_point_reg <= last_pt;
                epi_pkg::PT_SUS:  cur_point_reg <= sus_idx_reg;
                epi_pkg::PT_ADV: begin
                    cur_point_reg <= adv_pos;
                    pos_reg       <= adv_pos;
                end
                default: begin
                end
            endcase

            case (cmd.lv_sel)
                epi_pkg::LV_RD:   level_reg <= rd_data_reg.level;
                epi_pkg::LV_NEXT: level_reg <= b_level_reg;
                epi_pkg::LV_DIV:  level_reg <= div_level;
                default: begin
                end
            endcase

            if (cmd.frame_from_rd) begin
                cur_frame_reg <= rd_data_reg.frame;
            end else if (cmd.frame_inc && (cur_frame_reg != FRAME_MAX)) begin
                cur_frame_reg <= cur_frame_reg + FW'(1);
            end

            if (cmd.div_load) begin
                div_cnt_reg <= '0;
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg + NW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            item_reg <= s_data;
        end
        if (cmd.latch_a) begin
            a_frame_reg <= rd_data_reg.frame;
            a_level_reg <= rd_data_reg.level;
        end
        if (cmd.latch_b) begin
            b_frame_reg <= rd_data_reg.frame;
            b_level_reg <= rd_data_reg.level;
        end
        if (cmd.div_load) begin
            div_q_reg   <= prod;
            div_rem_reg <= '0;
            div_neg_reg <= !lvl_up;
        end else if (cmd.div_step) begin
            div_q_reg   <= {div_q_reg[DW-2:0], q_bit};
            div_rem_reg <= rem_next;
        end
        if (cmd.out_load) begin
            out_reg.active  <= (item_reg.kind == epi_pkg::KIND_TICK) && env_en_reg;
            out_reg.level   <= level_reg;
            out_reg.segment <= cur_point_reg;
        end
    end

    // point table
    always_ff @(posedge aclk) begin
        if (cmd.wr_point && wr_ok) begin
            mem[AW'(item_reg.point_index)] <= {item_reg.point_frame, item_reg.point_level};
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/envelope_point_interpolator_core.sv -----
// Flow: restart, write and disabled-tick words pass from decode to the output register;
// a tick reads the point table and, when it interpolates, runs the one-bit-per-cycle
// divider first. One word in flight; next word accepted right after.
// Reset (aresetn low, synchronous): position, frame and level cleared, configuration
// to defaults (point count 1), output empty. Point table is not cleared.
module envelope_point_interpolator_core #(
    parameter int unsigned MAX_POINTS = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // configuration write channel (always ready)
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [epi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [epi_pkg::CFG_DATA_W-1:0]    cfg_data,

    // input words: tick, restart, table write
    input  logic                              s_valid,
    output logic                              s_ready,
    input  epi_pkg::in_word_t                 s_data,

    // result words, one per input word
    output logic                              m_valid,
    input  logic                              m_ready,
    output epi_pkg::out_word_t                m_data
);

    // Controller/datapath split: the FSM in epi_ctrl sequences table reads,
    // the advance decision, the multiply and the serial divide; epi_dp holds
    // the config registers, the point table (one write, one registered read
    // per cycle), the envelope state and the output word register.
    //
    // The output register decouples the two sides: a new word is taken while
    // the previous result still waits for m_ready; the FSM only stalls at its
    // final state if that result has not been taken yet.

    epi_pkg::cmd_t    cmd;
    epi_pkg::status_t st;

    // Config writes are registered directly; the user must issue them only while idle (not enforced here).
    assign cfg_ready = 1'b1;

    epi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .st      (st),
        .cmd     (cmd)
    );

    epi_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .st        (st),
        .m_data    (m_data)
    );

endmodule
